// ----- rtl/rru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_pkg
// Shared types and codes for the register rename unit.
// ----------------------------------------------------------------------------
package rru_pkg;

  localparam int unsigned ARCH_BITS = 5;
  localparam int unsigned REG_BITS  = 7;

  typedef enum logic [1:0] {
    FUNC_RENAME = 2'd0,
    FUNC_RETIRE = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_HIST_EMPTY = 2'd2,
    ST_HIST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic       dest_valid;
    logic [6:0] dest_reg;
    logic [1:0] src_count;
    logic [6:0] src1_reg;
    logic [6:0] src2_reg;
    logic [6:0] src3_reg;
    logic       is_move;
    logic       is_load;
    logic       is_load_store;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] src1_phys;
    logic [6:0] src2_phys;
    logic [6:0] src3_phys;
    logic [6:0] dest_phys;
    logic [6:0] prev_phys;
    logic       load_producer;
    logic       mov_elim;
    logic       freed_valid;
    logic [6:0] freed_phys;
  } rsp_t;

endpackage

// ----- rtl/rru_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_req_if / rru_rsp_if
// Valid/ready channels that carry rename requests and results.
// ----------------------------------------------------------------------------
interface rru_req_if;
  logic          valid;
  logic          ready;
  rru_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rru_rsp_if;
  logic          valid;
  logic          ready;
  rru_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/register_rename_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_rename_unit
// Map table, free lists, reference counts and rename history.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready); each request produces
// exactly one result transaction on the rsp channel. A rename looks up up to
// three sources, then allocates or reuses a destination; retire and flush
// pop the oldest or youngest history entry and release one reference.
// Every state table sits in a single-port memory, so the sequencer walks the
// work through a series of states: for a rename the source lookups and, with
// a destination, the free-list read or move elimination, map read and write,
// reference count update, then the history push; for retire and flush a
// history read and the reference release. A stalled rename, an empty history
// or an unused function code goes straight to the result. The block takes
// one request at a time and is not ready while busy or while a result waits;
// a stalled receiver simply holds the result, and the block is ready again
// in the cycle after the result transaction. After reset a clearing pass
// initializes the map table, free lists, reference counts and load flags of
// all three register files before the first request is accepted. The user
// must write move_elim_en through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module register_rename_unit #(
  parameter int unsigned PHYS_REGS     = 128,
  parameter int unsigned REG_FILES     = 3,
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  rru_req_if.sink   req,
  rru_rsp_if.source rsp
);

  localparam int unsigned PB  = $clog2(PHYS_REGS);
  localparam int unsigned HB  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FB  = 2;
  localparam int unsigned RCB = 7;
  localparam int unsigned RB  = $clog2(3 * PHYS_REGS);
  localparam int unsigned MB  = $clog2(3 * 32);
  localparam logic [RCB-1:0] REF_MAX = '1;

  typedef struct packed {
    logic          dv;
    logic [FB-1:0] file;
    logic [4:0]    arch;
    logic [PB-1:0] phys;
    logic [PB-1:0] prev;
  } hist_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_SRC_RD, S_SRC_MAP, S_SRC_FLAG, S_FL_RD, S_FL_WAIT,
    S_MAP_RD, S_MAP_WAIT, S_MAP_WR, S_RC_RD, S_RC_WAIT, S_RC_WR, S_H_RD,
    S_H_WAIT, S_REL_RD, S_REL_WAIT, S_REL_WR, S_PUSH, S_OUT
  } state_t;

  logic [PB-1:0]   map_mem  [3*32];
  logic [PB-1:0]   fl_mem   [3*PHYS_REGS];
  logic [RCB-1:0]  rc_mem   [3*PHYS_REGS];
  logic            lf_mem   [3*PHYS_REGS];
  hist_t           h_mem    [HISTORY_DEPTH];

  state_t          state;
  rru_pkg::req_t   r;
  rru_pkg::rsp_t   o;
  logic            move_elim_en;
  logic [PB-1:0]   init_cnt;
  logic [FB-1:0]   init_f;
  logic [PB-1:0]   fhead [3];
  logic [PB:0]     fcnt  [3];
  logic [HB-1:0]   hhead;
  logic [HB:0]     hcnt;
  logic [1:0]      k;
  logic [PB-1:0]   sph [3];
  logic            slk [3];
  logic [FB-1:0]   sfl [3];
  logic            elim;
  logic [PB-1:0]   prf;
  logic [PB-1:0]   prev;
  logic [PB-1:0]   map_q;
  logic [PB-1:0]   fl_q;
  logic [RCB-1:0]  rc_q;
  logic            lf_q;
  hist_t           h_q;
  hist_t           he;
  logic [FB-1:0]   rel_f;
  logic [PB-1:0]   rel_p;

  logic [FB-1:0]   df;
  logic [4:0]      da;
  logic            drename;
  logic [6:0]      sreg;
  logic [FB-1:0]   sf;
  logic            s_skip;
  logic [HB:0]     hsum;
  logic [HB:0]     htop;
  logic [HB-1:0]   hidx_push;
  logic [HB-1:0]   hidx_top;
  logic [PB-1:0]   fhead_inc;
  logic [PB:0]     fsum;
  logic [PB-1:0]   fidx_push;

  function automatic logic [RB-1:0] ridx(input logic [FB-1:0] f, input logic [PB-1:0] p);
    return RB'(int'(f) * PHYS_REGS + int'(p));
  endfunction

  function automatic logic [MB-1:0] midx(input logic [FB-1:0] f, input logic [4:0] a);
    return MB'(int'(f) * 32 + int'(a));
  endfunction

  assign df = r.dest_reg[6:5];
  assign da = r.dest_reg[4:0];
  assign drename = r.dest_valid && (32'(df) < REG_FILES) && !(df == '0 && da == '0);
  always_comb begin
    unique case (k)
      2'd0:    sreg = r.src1_reg;
      2'd1:    sreg = r.src2_reg;
      default: sreg = r.src3_reg;
    endcase
  end
  assign sf = sreg[6:5];
  assign s_skip = (32'(sf) >= REG_FILES) || (sreg[6:5] == '0 && sreg[4:0] == '0);

  assign hsum = {1'b0, hhead} + hcnt;
  assign htop = hsum - (HB+1)'(1);
  assign hidx_push = (hsum >= (HB+1)'(HISTORY_DEPTH)) ?
                     HB'(hsum - (HB+1)'(HISTORY_DEPTH)) : HB'(hsum);
  assign hidx_top = (htop >= (HB+1)'(HISTORY_DEPTH)) ?
                    HB'(htop - (HB+1)'(HISTORY_DEPTH)) : HB'(htop);

  assign fhead_inc = (fhead[df] == PB'(PHYS_REGS - 1)) ? '0 : PB'(fhead[df] + 1'b1);
  assign fsum = {1'b0, fhead[rel_f]} + fcnt[rel_f];
  assign fidx_push = (fsum >= (PB+1)'(PHYS_REGS)) ?
                     PB'(fsum - (PB+1)'(PHYS_REGS)) : PB'(fsum);

  always_comb begin
    he.dv   = drename;
    he.file = drename ? df : '0;
    he.arch = drename ? da : '0;
    he.phys = prf;
    he.prev = prev;
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.payload = o;

  function automatic logic [6:0] p7(input logic [PB-1:0] v);
    logic [PB+6:0] w;
    w = {7'd0, v};
    return w[6:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      init_f <= '0;
      move_elim_en <= 1'b0;
      hhead <= '0;
      hcnt <= '0;
      for (int f = 0; f < 3; f++) begin
        fhead[f] <= '0;
        fcnt[f]  <= (PB+1)'(PHYS_REGS - 32);
      end
    end else begin
      if (cfg_we) move_elim_en <= cfg_wdata;
      unique case (state)
        S_INIT: begin
          rc_mem[ridx(init_f, init_cnt)] <=
            (init_cnt < PB'(32) && !(init_f == '0 && init_cnt == '0)) ? RCB'(1) : '0;
          lf_mem[ridx(init_f, init_cnt)] <= 1'b0;
          fl_mem[ridx(init_f, init_cnt)] <= PB'(init_cnt + PB'(32));
          if (init_cnt < PB'(32))
            map_mem[midx(init_f, init_cnt[4:0])] <= init_cnt;
          if (init_cnt == PB'(PHYS_REGS - 1)) begin
            init_cnt <= '0;
            if (init_f == FB'(2)) state <= S_IDLE;
            else init_f <= init_f + 1'b1;
          end else begin
            init_cnt <= init_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            r <= req.payload;
            o <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          k <= '0;
          elim <= 1'b0;
          prf <= '0;
          prev <= '0;
          for (int i = 0; i < 3; i++) begin
            sph[i] <= '0;
            slk[i] <= 1'b0;
            sfl[i] <= '0;
          end
          unique case (r.func)
            rru_pkg::FUNC_RENAME: begin
              if (drename && fcnt[df] == '0) begin
                o.status <= rru_pkg::ST_NO_FREE;
                state <= S_OUT;
              end else if (hcnt >= (HB+1)'(HISTORY_DEPTH)) begin
                o.status <= rru_pkg::ST_HIST_FULL;
                state <= S_OUT;
              end else begin
                state <= S_SRC_RD;
              end
            end
            rru_pkg::FUNC_RETIRE, rru_pkg::FUNC_FLUSH: begin
              if (hcnt == '0) begin
                o.status <= rru_pkg::ST_HIST_EMPTY;
                state <= S_OUT;
              end else begin
                state <= S_H_RD;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_SRC_RD: begin
          if (k >= r.src_count || k == 2'd3) begin
            state <= drename ? S_FL_RD : S_PUSH;
          end else if (s_skip) begin
            k <= k + 1'b1;
          end else begin
            map_q <= map_mem[midx(sf, sreg[4:0])];
            state <= S_SRC_MAP;
          end
        end
        S_SRC_MAP: begin
          sph[k] <= map_q;
          slk[k] <= 1'b1;
          sfl[k] <= sf;
          lf_q <= lf_mem[ridx(sf, map_q)];
          state <= S_SRC_FLAG;
        end
        S_SRC_FLAG: begin
          if (r.is_load_store && lf_q) o.load_producer <= 1'b1;
          k <= k + 1'b1;
          state <= S_SRC_RD;
        end
        S_FL_RD: begin
          if (move_elim_en && r.is_move && slk[0] && sfl[0] == df) begin
            prf <= sph[0]; elim <= 1'b1; state <= S_MAP_RD;
          end else if (move_elim_en && r.is_move && !r.is_load_store &&
                       slk[1] && sfl[1] == df) begin
            prf <= sph[1]; elim <= 1'b1; state <= S_MAP_RD;
          end else if (move_elim_en && r.is_move && !r.is_load_store &&
                       slk[2] && sfl[2] == df) begin
            prf <= sph[2]; elim <= 1'b1; state <= S_MAP_RD;
          end else begin
            fl_q <= fl_mem[ridx(df, fhead[df])];
            state <= S_FL_WAIT;
          end
        end
        S_FL_WAIT: begin
          prf <= fl_q;
          fhead[df] <= fhead_inc;
          fcnt[df] <= fcnt[df] - 1'b1;
          state <= S_MAP_RD;
        end
        S_MAP_RD: begin
          map_q <= map_mem[midx(df, da)];
          state <= S_MAP_WAIT;
        end
        S_MAP_WAIT: begin
          prev <= map_q;
          state <= S_MAP_WR;
        end
        S_MAP_WR: begin
          map_mem[midx(df, da)] <= prf;
          state <= S_RC_RD;
        end
        S_RC_RD: begin
          rc_q <= rc_mem[ridx(df, prf)];
          state <= S_RC_WAIT;
        end
        S_RC_WAIT: state <= S_RC_WR;
        S_RC_WR: begin
          if (rc_q < REF_MAX) rc_mem[ridx(df, prf)] <= rc_q + 1'b1;
          lf_mem[ridx(df, prf)] <= r.is_load;
          state <= S_PUSH;
        end
        S_PUSH: begin
          h_mem[hidx_push] <= he;
          hcnt <= hcnt + 1'b1;
          o.src1_phys <= p7(sph[0]);
          o.src2_phys <= p7(sph[1]);
          o.src3_phys <= p7(sph[2]);
          o.dest_phys <= p7(prf);
          o.prev_phys <= p7(prev);
          o.mov_elim <= elim;
          state <= S_OUT;
        end
        S_H_RD: begin
          h_q <= h_mem[(r.func == rru_pkg::FUNC_RETIRE) ? hhead : hidx_top];
          if (r.func == rru_pkg::FUNC_RETIRE)
            hhead <= (hhead == HB'(HISTORY_DEPTH - 1)) ? '0 : HB'(hhead + 1'b1);
          hcnt <= hcnt - 1'b1;
          state <= S_H_WAIT;
        end
        S_H_WAIT: begin
          if (!h_q.dv) begin
            state <= S_OUT;
          end else begin
            o.dest_phys <= p7(h_q.phys);
            o.prev_phys <= p7(h_q.prev);
            rel_f <= h_q.file;
            if (r.func == rru_pkg::FUNC_RETIRE) begin
              rel_p <= h_q.prev;
            end else begin
              rel_p <= h_q.phys;
              map_mem[midx(h_q.file, h_q.arch)] <= h_q.prev;
            end
            state <= S_REL_RD;
          end
        end
        S_REL_RD: begin
          rc_q <= rc_mem[ridx(rel_f, rel_p)];
          state <= S_REL_WAIT;
        end
        S_REL_WAIT: state <= S_REL_WR;
        S_REL_WR: begin
          if (rc_q != '0) begin
            rc_mem[ridx(rel_f, rel_p)] <= rc_q - 1'b1;
            if (rc_q == RCB'(1)) begin
              o.freed_valid <= 1'b1;
              o.freed_phys <= p7(rel_p);
              if (fcnt[rel_f] < (PB+1)'(PHYS_REGS)) begin
                fl_mem[ridx(rel_f, fidx_push)] <= rel_p;
                fcnt[rel_f] <= fcnt[rel_f] + 1'b1;
              end
            end
          end
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rru_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_checker
// Port-level checks for the register rename unit.
// ----------------------------------------------------------------------------
module rru_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input rru_pkg::rsp_t rsp_payload
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while a result waits");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result changed while stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("back-to-back accept");

  a_freed_phys: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_payload.freed_valid |-> rsp_payload.freed_phys == 7'd0)
    else $error("freed register without valid");

endmodule

bind register_rename_unit rru_checker u_rru_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ----- tb/register_rename_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_rename_unit_tb
// Self-checking bench for the register rename unit.
// ----------------------------------------------------------------------------
// A directed table covers the reset mappings, empty history, x0 handling,
// missing files, move elimination, load producers and unused function codes.
// Random traffic then mixes renames, retires and flushes: it fills and drains
// the history and the free lists under random idling on both channels.
// A predictor of the rename state computes the result of every accepted
// request; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module register_rename_unit_tb;

  localparam int NP = 128;
  localparam int NF = 3;
  localparam int HD = 64;
  localparam int WATCHDOG = 20000;
  localparam int EXP_SLOTS = 8;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rru_req_if req ();
  rru_rsp_if rsp ();

  register_rename_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req.sink),
    .rsp(rsp.source)
  );

  typedef struct {
    bit       dv;
    bit [1:0] file;
    bit [4:0] arch;
    bit [6:0] phys;
    bit [6:0] prev;
  } rename_rec_t;

  typedef struct {
    rru_pkg::req_t rq;
    bit            has_exp;
    rru_pkg::rsp_t exp;
  } dir_row_t;

  bit [6:0] map_q[NF][32];
  bit [6:0] free_q[NF][NP];
  int       free_hd[NF];
  int       free_cnt[NF];
  bit [6:0] refs[NF][NP];
  bit       ldflag[NF][NP];
  rename_rec_t hist[HD];
  int       hist_hd;
  int       hist_cnt;
  bit       elim_en;

  rru_pkg::rsp_t exp_ring[EXP_SLOTS];
  int   exp_wr;
  int   exp_rd;
  dir_row_t rows[16];
  int   n_rows;
  int   errors;
  int   sent;
  int   received;
  int   idle_cycles;
  bit   timed_out;
  int   n_elim;
  int   n_freed;
  int   n_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic free_push(int f, int p);
    if (free_cnt[f] < NP) begin
      free_q[f][(free_hd[f] + free_cnt[f]) % NP] = p[6:0];
      free_cnt[f]++;
    end
  endtask

  task automatic release_phys(int f, int p, output bit freed);
    freed = 1'b0;
    if (refs[f][p] != 0) begin
      refs[f][p]--;
      if (refs[f][p] == 0) begin
        free_push(f, p);
        freed = 1'b1;
      end
    end
  endtask

  task automatic rename_state_reset();
    for (int f = 0; f < NF; f++) begin
      for (int p = 0; p < NP; p++) begin
        refs[f][p] = 0;
        ldflag[f][p] = 0;
      end
      for (int a = 0; a < 32; a++) begin
        map_q[f][a] = a[6:0];
        refs[f][a] = (f == 0 && a == 0) ? 7'd0 : 7'd1;
      end
      free_hd[f] = 0;
      free_cnt[f] = 0;
      for (int p = 32; p < NP; p++) free_push(f, p);
    end
    hist_hd = 0;
    hist_cnt = 0;
    elim_en = 1'b0;
  endtask

  task automatic predict_rename(input rru_pkg::req_t rq, output rru_pkg::rsp_t r);
    rename_rec_t e;
    bit freed;
    int fp;
    int df;
    int da;
    bit dren;
    int sphys[3];
    bit slook[3];
    int sfile[3];
    bit ldp;
    bit elim;
    int prf;
    int prev;
    int rg;
    r = '0;
    if (rq.func == rru_pkg::FUNC_RETIRE || rq.func == rru_pkg::FUNC_FLUSH) begin
      if (hist_cnt == 0) begin
        r.status = rru_pkg::ST_HIST_EMPTY;
        return;
      end
      if (rq.func == rru_pkg::FUNC_RETIRE) begin
        e = hist[hist_hd];
        hist_hd = (hist_hd + 1) % HD;
      end else begin
        e = hist[(hist_hd + hist_cnt - 1) % HD];
      end
      hist_cnt--;
      freed = 1'b0;
      fp = 0;
      if (e.dv) begin
        if (rq.func == rru_pkg::FUNC_RETIRE) begin
          release_phys(e.file, e.prev, freed);
          fp = e.prev;
        end else begin
          map_q[e.file][e.arch] = e.prev;
          release_phys(e.file, e.phys, freed);
          fp = e.phys;
        end
        r.dest_phys = e.phys;
        r.prev_phys = e.prev;
      end
      r.freed_valid = freed;
      r.freed_phys = freed ? fp[6:0] : 7'd0;
      return;
    end
    if (rq.func != rru_pkg::FUNC_RENAME) return;
    df = rq.dest_reg[6:5];
    da = rq.dest_reg[4:0];
    dren = rq.dest_valid && df < NF && !(df == 0 && da == 0);
    if (dren && free_cnt[df] == 0) begin
      r.status = rru_pkg::ST_NO_FREE;
      return;
    end
    if (hist_cnt >= HD) begin
      r.status = rru_pkg::ST_HIST_FULL;
      return;
    end
    ldp = 0;
    elim = 0;
    prf = 0;
    prev = 0;
    for (int k = 0; k < 3; k++) begin
      sphys[k] = 0;
      slook[k] = 0;
      sfile[k] = 0;
      if (k < rq.src_count) begin
        rg = (k == 0) ? rq.src1_reg : (k == 1) ? rq.src2_reg : rq.src3_reg;
        if (!(rg[6:5] >= NF || rg == 0)) begin
          sphys[k] = map_q[rg[6:5]][rg[4:0]];
          slook[k] = 1;
          sfile[k] = rg[6:5];
          if (rq.is_load_store && ldflag[sfile[k]][sphys[k]]) ldp = 1;
        end
      end
    end
    if (dren) begin
      if (elim_en && rq.is_move) begin
        for (int k = 0; k < 3; k++) begin
          if (!elim && slook[k] && sfile[k] == df && !(k > 0 && rq.is_load_store)) begin
            prf = sphys[k];
            elim = 1;
          end
        end
      end
      if (!elim) begin
        prf = free_q[df][free_hd[df]];
        free_hd[df] = (free_hd[df] + 1) % NP;
        free_cnt[df]--;
      end
      prev = map_q[df][da];
      map_q[df][da] = prf[6:0];
      if (refs[df][prf] < 7'd127) refs[df][prf]++;
      ldflag[df][prf] = rq.is_load;
    end
    e.dv = dren;
    e.file = dren ? df[1:0] : 2'd0;
    e.arch = dren ? da[4:0] : 5'd0;
    e.phys = prf[6:0];
    e.prev = prev[6:0];
    hist[(hist_hd + hist_cnt) % HD] = e;
    hist_cnt++;
    r.src1_phys = sphys[0][6:0];
    r.src2_phys = sphys[1][6:0];
    r.src3_phys = sphys[2][6:0];
    r.dest_phys = prf[6:0];
    r.prev_phys = prev[6:0];
    r.load_producer = ldp;
    r.mov_elim = elim;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  task automatic compare_rsp(rru_pkg::rsp_t got, rru_pkg::rsp_t want);
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.src1_phys != want.src1_phys)
      report_mismatch("src1_phys", got.src1_phys, want.src1_phys);
    if (got.src2_phys != want.src2_phys)
      report_mismatch("src2_phys", got.src2_phys, want.src2_phys);
    if (got.src3_phys != want.src3_phys)
      report_mismatch("src3_phys", got.src3_phys, want.src3_phys);
    if (got.dest_phys != want.dest_phys)
      report_mismatch("dest_phys", got.dest_phys, want.dest_phys);
    if (got.prev_phys != want.prev_phys)
      report_mismatch("prev_phys", got.prev_phys, want.prev_phys);
    if (got.load_producer != want.load_producer)
      report_mismatch("load_producer", got.load_producer, want.load_producer);
    if (got.mov_elim != want.mov_elim)
      report_mismatch("mov_elim", got.mov_elim, want.mov_elim);
    if (got.freed_valid != want.freed_valid)
      report_mismatch("freed_valid", got.freed_valid, want.freed_valid);
    if (got.freed_phys != want.freed_phys)
      report_mismatch("freed_phys", got.freed_phys, want.freed_phys);
  endtask

  // Result side: random stalls, in-order checking.
  initial begin
    rru_pkg::rsp_t want;
    int hold;
    rsp.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk iff rsp.valid);
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = exp_ring[exp_rd % EXP_SLOTS];
        exp_rd++;
        compare_rsp(rsp.payload, want);
      end
      received++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_req(rru_pkg::req_t rq, bit has_exp, rru_pkg::rsp_t typed_exp);
    rru_pkg::rsp_t r;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.payload <= rq;
    req.valid <= 1'b1;
    @(posedge clk iff req.ready);
    predict_rename(rq, r);
    if (has_exp) compare_rsp(r, typed_exp);
    if (r.mov_elim) n_elim++;
    if (r.freed_valid) n_freed++;
    if (r.status == rru_pkg::ST_NO_FREE || r.status == rru_pkg::ST_HIST_FULL) n_stall++;
    exp_ring[exp_wr % EXP_SLOTS] = r;
    exp_wr++;
    sent++;
  endtask

  task automatic stop_sending();
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_elim(bit v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    elim_en = v;
  endtask

  task automatic add_row(rru_pkg::req_t rq, bit has_exp, rru_pkg::rsp_t exp);
    rows[n_rows] = '{rq, has_exp, exp};
    n_rows++;
  endtask

  function automatic rru_pkg::req_t mk(rru_pkg::func_t fn, bit dv, int d, int n, int s1,
                                       int s2, int s3, bit mv, bit ld, bit ls);
    rru_pkg::req_t q;
    q.func = fn;
    q.dest_valid = dv;
    q.dest_reg = d[6:0];
    q.src_count = n[1:0];
    q.src1_reg = s1[6:0];
    q.src2_reg = s2[6:0];
    q.src3_reg = s3[6:0];
    q.is_move = mv;
    q.is_load = ld;
    q.is_load_store = ls;
    return q;
  endfunction

  function automatic rru_pkg::rsp_t mkr(rru_pkg::status_t st, int s1, int s2, int s3,
                                        int d, int p, bit lp, bit me, bit fv, int fp);
    rru_pkg::rsp_t r;
    r.status = st;
    r.src1_phys = s1[6:0];
    r.src2_phys = s2[6:0];
    r.src3_phys = s3[6:0];
    r.dest_phys = d[6:0];
    r.prev_phys = p[6:0];
    r.load_producer = lp;
    r.mov_elim = me;
    r.freed_valid = fv;
    r.freed_phys = fp[6:0];
    return r;
  endfunction

  function automatic rru_pkg::req_t rand_req(int mode);
    rru_pkg::req_t q;
    logic [63:0] raw;
    int pick;
    raw = {$urandom, $urandom};
    q = raw[$bits(rru_pkg::req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (q.dest_reg > 95 && $urandom_range(0, 7) != 0) q.dest_reg = 7'($urandom_range(0, 95));
    if (q.src1_reg > 95 && $urandom_range(0, 7) != 0) q.src1_reg = 7'($urandom_range(0, 95));
    if (q.src2_reg > 95 && $urandom_range(0, 7) != 0) q.src2_reg = 7'($urandom_range(0, 95));
    if (q.src3_reg > 95 && $urandom_range(0, 7) != 0) q.src3_reg = 7'($urandom_range(0, 95));
    // Mode 0 fills the history, mode 1 drains it, mode 2 is balanced.
    if (pick < 2) q.func = rru_pkg::FUNC_NONE;
    else if (pick < (mode == 0 ? 88 : mode == 1 ? 25 : 55)) q.func = rru_pkg::FUNC_RENAME;
    else if (pick < (mode == 1 ? 80 : 90)) q.func = rru_pkg::FUNC_RETIRE;
    else q.func = rru_pkg::FUNC_FLUSH;
    if ($urandom_range(0, 3) == 0) begin
      q.is_move = 1'b1;
      q.src1_reg = {q.dest_reg[6:5], q.src1_reg[4:0]};
    end
    return q;
  endfunction

  initial begin
    rru_pkg::rsp_t none;
    int mode;
    bit pass_ok;
    errors = 0;
    sent = 0;
    received = 0;
    exp_wr = 0;
    exp_rd = 0;
    n_rows = 0;
    n_elim = 0;
    n_freed = 0;
    n_stall = 0;
    timed_out = 0;
    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req.valid = 1'b0;
    req.payload = '0;
    rename_state_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(mk(rru_pkg::FUNC_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mkr(rru_pkg::ST_HIST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rru_pkg::FUNC_FLUSH, 1, 127, 3, 127, 127, 127, 1, 1, 1), 1,
            mkr(rru_pkg::ST_HIST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rru_pkg::FUNC_NONE, 1, 127, 3, 127, 127, 127, 1, 1, 1), 1,
            mkr(rru_pkg::ST_DONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 5, 3, 0, 33, 95, 0, 1, 0), 1,
            mkr(rru_pkg::ST_DONE, 0, 1, 31, 32, 5, 0, 0, 0, 0));
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 0, 3, 5, 100, 127, 0, 0, 1), 1,
            mkr(rru_pkg::ST_DONE, 32, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 96, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RENAME, 0, 95, 2, 64, 31, 0, 1, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 63, 1, 63, 0, 0, 1, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    for (int i = 0; i < n_rows; i++) send_req(rows[i].rq, rows[i].has_exp, rows[i].exp);
    stop_sending();
    wait_drained();

    write_elim(1'b1);
    n_rows = 0;
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 40, 1, 41, 0, 0, 1, 1, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 42, 3, 5, 40, 43, 1, 0, 1), 0, none);
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 70, 2, 0, 71, 0, 1, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RENAME, 1, 3, 2, 2, 2, 0, 1, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(rru_pkg::FUNC_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    for (int i = 0; i < n_rows; i++) send_req(rows[i].rq, rows[i].has_exp, rows[i].exp);
    stop_sending();
    wait_drained();

    // Random phases with the move elimination setting toggled between them.
    for (int ph = 0; ph < 8; ph++) begin
      write_elim(ph[0]);
      for (int i = 0; i < 250; i++) begin
        mode = ((i / 80) + ph) % 3;
        send_req(rand_req(mode), 0, none);
      end
      stop_sending();
      wait_drained();
    end

    $display("Sent %0d requests: %0d move eliminations, %0d registers freed, %0d stalls.",
             sent, n_elim, n_freed, n_stall);
    pass_ok = (errors == 0) && (exp_wr == exp_rd) && !timed_out;
    if (pass_ok) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    @(posedge clk iff idle_cycles >= WATCHDOG);
    timed_out = 1;
    $display("Watchdog expired with %0d results outstanding.", exp_wr - exp_rd);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
